/* rtl/smart_card_atr_validator_macros.svh */
// Assertion macros shared by the ATR validator RTL.
`ifndef SMART_CARD_ATR_VALIDATOR_MACROS_SVH
`define SMART_CARD_ATR_VALIDATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define SCAV_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted (active low).
`define SCAV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/scav_pkg.sv */
// Types and constants shared by the ATR validator modules.
package scav_pkg;

    typedef enum logic [2:0] {
        PH_TS    = 3'd0,
        PH_T0    = 3'd1,
        PH_IFACE = 3'd2,
        PH_HIST  = 3'd3,
        PH_TCK   = 3'd4,
        PH_DONE  = 3'd5
    } t_phase;

    typedef enum logic [3:0] {
        KIND_TS     = 4'd0,
        KIND_T0     = 4'd1,
        KIND_TA     = 4'd2,
        KIND_TB     = 4'd3,
        KIND_TC     = 4'd4,
        KIND_TD     = 4'd5,
        KIND_HIST   = 4'd6,
        KIND_TCK    = 4'd7,
        KIND_EXCESS = 4'd8
    } t_kind;

    typedef enum logic [3:0] {
        ERR_NONE       = 4'd0,
        ERR_FI         = 4'd1,
        ERR_DI         = 4'd2,
        ERR_TA2_RFU    = 4'd3,
        ERR_TC2        = 4'd4,
        ERR_IFSC       = 4'd5,
        ERR_BWI        = 4'd6,
        ERR_TC_T1      = 4'd7,
        ERR_CLASS      = 4'd8,
        ERR_TRUNC      = 4'd9,
        ERR_HIST_SHORT = 4'd10,
        ERR_TCK_ABSENT = 4'd11,
        ERR_TCK_BAD    = 4'd12,
        ERR_EXCESS     = 4'd13
    } t_err;

    // What the structure still expects once the current byte is taken.
    typedef enum logic [1:0] {
        END_NONE  = 2'd0,
        END_TRUNC = 2'd1,
        END_HIST  = 2'd2,
        END_TCK   = 2'd3
    } t_end;

    localparam logic [15:0] FI_BAD_MASK    = 16'hC180;
    localparam logic [15:0] DI_BAD_MASK    = 16'hFC01;
    localparam logic [7:0]  TA2_RFU_MASK   = 8'h60;
    localparam logic [7:0]  BYTE_ONES      = 8'hFF;
    localparam logic [7:0]  BWI_MASK       = 8'hF0;
    localparam logic [7:0]  BWI_MAX        = 8'h90;
    localparam logic [7:0]  TC_T1_MASK     = 8'hFE;
    localparam logic [7:0]  CLASS_RFU_MASK = 8'h38;
    localparam logic [7:0]  CLASS_MASK     = 8'h07;
    localparam logic [3:0]  PROT_T1        = 4'd1;
    localparam logic [3:0]  PROT_T15       = 4'd15;
    localparam logic [3:0]  GROUP_MAX      = 4'd15;
    localparam logic [3:0]  GROUP_FIRST    = 4'd1;
    localparam logic [3:0]  GROUP_SECOND   = 4'd2;
    localparam logic [1:0]  MARK_T15_TA    = 2'd3;

    // Classified byte handed from the front to the back.
    typedef struct packed {
        logic [7:0] data;
        t_kind      kind;
        logic [3:0] group;
        logic [3:0] proto;
        logic       last;
        t_end       end_chk;
    } t_item;

    typedef struct packed {
        t_kind      kind;
        logic [3:0] group;
        logic [3:0] proto;
        t_err       err;
        logic       done;
        logic       ok;
    } t_result;

    // Queue occupancy seen by the front and the back.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

/* rtl/scav_front.sv */
// Front end: accepts ATR bytes, tracks the structure and classifies each byte.
module scav_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [7:0]      i_data_byte,
    input  logic            i_is_last,
    input  scav_pkg::t_q_stat i_q_stat,
    output logic            o_stall,
    output logic            o_push,
    output scav_pkg::t_item o_item
);
    import scav_pkg::*;

    t_phase     r_phase, n_phase, s_phase;
    logic [3:0] r_pend, n_pend, s_pend;
    logic [3:0] r_group, n_group, s_group;
    logic [3:0] r_proto, n_proto, s_proto;
    logic [3:0] r_hist, n_hist, s_hist;
    logic       r_tck, n_tck, s_tck;
    logic       w_accept;
    logic [1:0] w_k;

    function automatic t_phase after_iface(input logic [3:0] hist, input logic tck);
        if (hist != 4'd0) begin
            return PH_HIST;
        end else if (tck) begin
            return PH_TCK;
        end else begin
            return PH_DONE;
        end
    endfunction

    assign o_stall  = i_q_stat.full;
    assign w_accept = i_valid && !i_q_stat.full;
    assign o_push   = w_accept;

    // Lowest pending indicator picks TA, TB, TC, then TD.
    always_comb begin
        if (r_pend[0]) begin
            w_k = 2'd0;
        end else if (r_pend[1]) begin
            w_k = 2'd1;
        end else if (r_pend[2]) begin
            w_k = 2'd2;
        end else begin
            w_k = 2'd3;
        end
    end

    // Next state.
    always_comb begin
        s_phase = r_phase;
        s_pend  = r_pend;
        s_group = r_group;
        s_proto = r_proto;
        s_hist  = r_hist;
        s_tck   = r_tck;
        case (r_phase)
            PH_TS: begin
                s_phase = PH_T0;
            end
            PH_T0: begin
                s_pend  = i_data_byte[7:4];
                s_hist  = i_data_byte[3:0];
                s_group = GROUP_FIRST;
                if (i_data_byte[7:4] != 4'd0) begin
                    s_phase = PH_IFACE;
                end else begin
                    s_phase = after_iface(i_data_byte[3:0], r_tck);
                end
            end
            PH_IFACE: begin
                if (w_k == 2'd3) begin
                    s_proto = i_data_byte[3:0];
                    s_tck   = r_tck || (i_data_byte[3:0] != 4'd0);
                    s_pend  = i_data_byte[7:4];
                    if (r_group < GROUP_MAX) begin
                        s_group = r_group + 4'd1;
                    end
                end else begin
                    s_pend = r_pend & ~(4'b0001 << w_k);
                end
                if (s_pend == 4'd0) begin
                    s_phase = after_iface(r_hist, s_tck);
                end
            end
            PH_HIST: begin
                s_hist = r_hist - 4'd1;
                if (s_hist == 4'd0) begin
                    s_phase = r_tck ? PH_TCK : PH_DONE;
                end
            end
            PH_TCK: begin
                s_phase = PH_DONE;
            end
            default: begin
                s_phase = PH_DONE;
            end
        endcase

        n_phase = r_phase;
        n_pend  = r_pend;
        n_group = r_group;
        n_proto = r_proto;
        n_hist  = r_hist;
        n_tck   = r_tck;
        if (w_accept) begin
            if (i_is_last) begin
                n_phase = PH_TS;
                n_pend  = 4'd0;
                n_group = 4'd0;
                n_proto = 4'd0;
                n_hist  = 4'd0;
                n_tck   = 1'b0;
            end else begin
                n_phase = s_phase;
                n_pend  = s_pend;
                n_group = s_group;
                n_proto = s_proto;
                n_hist  = s_hist;
                n_tck   = s_tck;
            end
        end
    end

    // Classification outputs.
    always_comb begin
        o_item.data  = i_data_byte;
        o_item.last  = i_is_last;
        o_item.proto = s_proto;
        o_item.group = 4'd0;
        case (r_phase)
            PH_TS:    o_item.kind = KIND_TS;
            PH_T0:    o_item.kind = KIND_T0;
            PH_IFACE: begin
                o_item.group = r_group;
                case (w_k)
                    2'd0:    o_item.kind = KIND_TA;
                    2'd1:    o_item.kind = KIND_TB;
                    2'd2:    o_item.kind = KIND_TC;
                    default: o_item.kind = KIND_TD;
                endcase
            end
            PH_HIST:  o_item.kind = KIND_HIST;
            PH_TCK:   o_item.kind = KIND_TCK;
            default:  o_item.kind = KIND_EXCESS;
        endcase
        case (s_phase)
            PH_T0, PH_IFACE: o_item.end_chk = END_TRUNC;
            PH_HIST:         o_item.end_chk = END_HIST;
            PH_TCK:          o_item.end_chk = END_TCK;
            default:         o_item.end_chk = END_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_TS;
            r_pend  <= 4'd0;
            r_group <= 4'd0;
            r_proto <= 4'd0;
            r_hist  <= 4'd0;
            r_tck   <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_pend  <= n_pend;
            r_group <= n_group;
            r_proto <= n_proto;
            r_hist  <= n_hist;
            r_tck   <= n_tck;
        end
    end

endmodule

/* rtl/scav_queue.sv */
// Two-entry queue of classified bytes between the front and the back.
module scav_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  scav_pkg::t_item   i_item,
    input  logic              i_pop,
    output scav_pkg::t_q_stat o_stat,
    output scav_pkg::t_item   o_head
);
    import scav_pkg::*;

    t_item      r_mem [2];
    logic       r_wptr, n_wptr;
    logic       r_rptr, n_rptr;
    logic [1:0] r_count, n_count;

    assign o_stat.full  = (r_count == 2'd2);
    assign o_stat.empty = (r_count == 2'd0);
    assign o_head       = r_mem[r_rptr];

    always_comb begin
        n_wptr  = i_push ? ~r_wptr : r_wptr;
        n_rptr  = i_pop ? ~r_rptr : r_rptr;
        n_count = r_count + {1'b0, i_push} - {1'b0, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

endmodule

/* rtl/scav_back.sv */
// Back end: runs the byte checks, the check-byte XOR and the verdict.
module scav_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  scav_pkg::t_q_stat i_q_stat,
    input  scav_pkg::t_item   i_item,
    input  logic              i_out_stall,
    output logic              o_pop,
    output logic              o_valid,
    output scav_pkg::t_result o_result
);
    import scav_pkg::*;

    logic       r_valid, n_valid;
    t_result    r_res, n_res;
    t_err       r_err, n_err;
    logic [7:0] r_xor, n_xor;
    logic [3:0] r_marks, n_marks;
    logic       w_load;
    logic [7:0] w_xor;
    logic [3:0] w_marks;
    logic [1:0] w_k;
    logic [7:0] w_b;
    t_err       w_chk;
    t_err       w_endc;
    t_err       w_err;

    assign w_load  = !i_q_stat.empty && (!r_valid || !i_out_stall);
    assign o_pop   = w_load;
    assign o_valid = r_valid;
    assign o_result = r_res;
    assign w_b     = i_item.data;
    assign w_k     = 2'(i_item.kind - KIND_TA);
    assign w_xor   = (i_item.kind == KIND_TS) ? r_xor : (r_xor ^ w_b);

    always_comb begin
        w_chk   = ERR_NONE;
        w_marks = r_marks;
        case (i_item.kind)
            KIND_TA, KIND_TB, KIND_TC: begin
                if (i_item.group == GROUP_FIRST) begin
                    if (i_item.kind == KIND_TA) begin
                        if (FI_BAD_MASK[w_b[7:4]]) begin
                            w_chk = ERR_FI;
                        end else if (DI_BAD_MASK[w_b[3:0]]) begin
                            w_chk = ERR_DI;
                        end
                    end
                end else if (i_item.group == GROUP_SECOND) begin
                    if (i_item.kind == KIND_TA && (w_b & TA2_RFU_MASK) != 8'd0) begin
                        w_chk = ERR_TA2_RFU;
                    end
                    if (i_item.kind == KIND_TC && w_b == 8'd0) begin
                        w_chk = ERR_TC2;
                    end
                end else if (i_item.proto == PROT_T1) begin
                    if (!r_marks[w_k]) begin
                        w_marks[w_k] = 1'b1;
                        if (i_item.kind == KIND_TA && (w_b == 8'd0 || w_b == BYTE_ONES)) begin
                            w_chk = ERR_IFSC;
                        end
                        if (i_item.kind == KIND_TB && (w_b & BWI_MASK) > BWI_MAX) begin
                            w_chk = ERR_BWI;
                        end
                        if (i_item.kind == KIND_TC && (w_b & TC_T1_MASK) != 8'd0) begin
                            w_chk = ERR_TC_T1;
                        end
                    end
                end else if (i_item.proto == PROT_T15 && i_item.kind == KIND_TA) begin
                    if (!r_marks[MARK_T15_TA]) begin
                        w_marks[MARK_T15_TA] = 1'b1;
                        if ((w_b & CLASS_RFU_MASK) != 8'd0 || (w_b & CLASS_MASK) == 8'd0) begin
                            w_chk = ERR_CLASS;
                        end
                    end
                end
            end
            KIND_TCK: begin
                if (w_xor != 8'd0) begin
                    w_chk = ERR_TCK_BAD;
                end
            end
            KIND_EXCESS: begin
                w_chk = ERR_EXCESS;
            end
            default: begin
                w_chk = ERR_NONE;
            end
        endcase
    end

    always_comb begin
        w_endc = ERR_NONE;
        if (i_item.last) begin
            case (i_item.end_chk)
                END_TRUNC: w_endc = ERR_TRUNC;
                END_HIST:  w_endc = ERR_HIST_SHORT;
                END_TCK:   w_endc = ERR_TCK_ABSENT;
                default:   w_endc = ERR_NONE;
            endcase
        end
        // Keep the first error found.
        if (r_err != ERR_NONE) begin
            w_err = r_err;
        end else if (w_chk != ERR_NONE) begin
            w_err = w_chk;
        end else begin
            w_err = w_endc;
        end
    end

    always_comb begin
        n_valid = r_valid;
        n_res   = r_res;
        n_err   = r_err;
        n_xor   = r_xor;
        n_marks = r_marks;
        if (w_load) begin
            n_valid      = 1'b1;
            n_res.kind   = i_item.kind;
            n_res.group  = i_item.group;
            n_res.proto  = i_item.proto;
            n_res.err    = w_err;
            n_res.done   = i_item.last;
            n_res.ok     = i_item.last && (w_err == ERR_NONE);
            if (i_item.last) begin
                n_err   = ERR_NONE;
                n_xor   = 8'd0;
                n_marks = 4'd0;
            end else begin
                n_err   = w_err;
                n_xor   = w_xor;
                n_marks = w_marks;
            end
        end else if (!i_out_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_err   <= ERR_NONE;
            r_xor   <= 8'd0;
            r_marks <= 4'd0;
        end else begin
            r_valid <= n_valid;
            r_err   <= n_err;
            r_xor   <= n_xor;
            r_marks <= n_marks;
        end
    end

endmodule

/* rtl/smart_card_atr_validator.sv */
// Top level of the smart-card Answer-to-Reset validator.
//
// Usage:
//   Input channel: one ATR byte per item on i_data_byte, starting with TS,
//   with i_is_last high on the final byte. An item is taken at a clock edge
//   where i_valid is high and o_stall is low.
//   Output channel: one result item per input byte (kind, group, protocol T,
//   first error so far, done flag and verdict), taken where o_valid is high
//   and i_stall is low.
//   Path: an accepted byte passes from the front into a queue entry, then from
//   the queue head into the output register.
//   Throughput: one byte per cycle while no stall holds the flow, as neither the
//   front end nor the back end has a busy state between bytes.
//   The last byte of an ATR returns all parse state to the TS expectation,
//   so the next ATR may follow in the very next cycle.
//   Reset (i_rst_n low, synchronous) empties the queue and the output register
//   and puts the parser at the TS byte with no error recorded.
//   When the receiver stalls, the result holds and the two-entry queue fills;
//   o_stall rises once both entries are taken.
`include "smart_card_atr_validator_macros.svh"

module smart_card_atr_validator (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_is_last,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [3:0] o_byte_kind,
    output logic [3:0] o_group_number,
    output logic [3:0] o_protocol_t,
    output logic [3:0] o_error_code,
    output logic       o_done_res,
    output logic       o_atr_ok
);
    import scav_pkg::*;

    t_q_stat w_q_stat;
    t_item   w_push_item;
    t_item   w_head;
    logic    w_push;
    logic    w_pop;
    t_result w_res;

    // Front: classify each byte and advance the structure tracker.
    scav_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_data_byte (i_data_byte),
        .i_is_last   (i_is_last),
        .i_q_stat    (w_q_stat),
        .o_stall     (o_stall),
        .o_push      (w_push),
        .o_item      (w_push_item)
    );

    // Queue: decouple classification from checking so each side stalls alone.
    scav_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .i_pop   (w_pop),
        .o_stat  (w_q_stat),
        .o_head  (w_head)
    );

    // Back: run the value checks, hold the sticky error, drive the result.
    scav_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_stat    (w_q_stat),
        .i_item      (w_head),
        .i_out_stall (i_stall),
        .o_pop       (w_pop),
        .o_valid     (o_valid),
        .o_result    (w_res)
    );

    assign o_byte_kind    = w_res.kind;
    assign o_group_number = w_res.group;
    assign o_protocol_t   = w_res.proto;
    assign o_error_code   = w_res.err;
    assign o_done_res     = w_res.done;
    assign o_atr_ok       = w_res.ok;

    // An accepted byte is in the queue at the next edge.
    `SCAV_ASSERT_NEXT(a_push_lands, i_clk, i_rst_n, i_valid && !o_stall, !w_q_stat.empty, "accepted byte missing from queue")

    // A passing verdict only comes on a finished ATR with no error.
    `SCAV_ASSERT_SAME(a_ok_clean, i_clk, i_rst_n, o_valid && o_atr_ok, o_done_res && (o_error_code == ERR_NONE), "atr_ok without clean finish")

    // Only interface bytes carry a group number.
    `SCAV_ASSERT_SAME(a_group_iface, i_clk, i_rst_n, o_valid && (o_byte_kind != KIND_TA) && (o_byte_kind != KIND_TB) && (o_byte_kind != KIND_TC) && (o_byte_kind != KIND_TD), o_group_number == 4'd0, "group number on non-interface byte")

    // The queue never reports full and empty together.
    `SCAV_ASSERT_SAME(a_queue_stat, i_clk, i_rst_n, w_q_stat.full, !w_q_stat.empty, "queue status inconsistent")

endmodule

/* bench/smart_card_atr_validator_tb.sv */
// Self-checking testbench for the smart-card Answer-to-Reset validator.
module smart_card_atr_validator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import scav_pkg::*;

    // Give the run a generous ceiling: about a thousand bytes with random
    // gaps on both sides finish in a small fraction of this.
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_BYTES = 1000;
    localparam int HOLD_CYCLES  = 80;
    localparam int MAX_REPORTS  = 10;

    // One row of the directed table. Where typed is set, res holds the
    // result read straight off the ATR rules; otherwise the predictor decides.
    typedef struct packed {
        logic [7:0] data;
        logic       is_final;
        logic       typed;
        t_result    res;
    } t_stim_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic [7:0] i_data_byte = 8'h00;
    logic       i_is_last = 1'b0;
    logic       i_stall = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [3:0] o_byte_kind;
    logic [3:0] o_group_number;
    logic [3:0] o_protocol_t;
    logic [3:0] o_error_code;
    logic       o_done_res;
    logic       o_atr_ok;

    smart_card_atr_validator uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_data_byte    (i_data_byte),
        .i_is_last      (i_is_last),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_byte_kind    (o_byte_kind),
        .o_group_number (o_group_number),
        .o_protocol_t   (o_protocol_t),
        .o_error_code   (o_error_code),
        .o_done_res     (o_done_res),
        .o_atr_ok       (o_atr_ok)
    );

    always #6 i_clk = ~i_clk;

    // Directed table: TS alone, minimal ATR, excess byte, bad Fi, bad Di,
    // short history, missing TCK, bad TCK, and a TB1/TC1 pair. TS values
    // span both byte extremes to show any TS is taken.
    t_stim_row directed_rows [26] = '{
        '{8'h3B, 1'b1, 1'b1, '{KIND_TS,     4'd0, 4'd0, ERR_TRUNC,      1'b1, 1'b0}},
        '{8'h3B, 1'b0, 1'b1, '{KIND_TS,     4'd0, 4'd0, ERR_NONE,       1'b0, 1'b0}},
        '{8'h00, 1'b1, 1'b1, '{KIND_T0,     4'd0, 4'd0, ERR_NONE,       1'b1, 1'b1}},
        '{8'h00, 1'b0, 1'b1, '{KIND_TS,     4'd0, 4'd0, ERR_NONE,       1'b0, 1'b0}},
        '{8'h00, 1'b0, 1'b1, '{KIND_T0,     4'd0, 4'd0, ERR_NONE,       1'b0, 1'b0}},
        '{8'hFF, 1'b1, 1'b1, '{KIND_EXCESS, 4'd0, 4'd0, ERR_EXCESS,     1'b1, 1'b0}},
        '{8'h3F, 1'b0, 1'b1, '{KIND_TS,     4'd0, 4'd0, ERR_NONE,       1'b0, 1'b0}},
        '{8'h10, 1'b0, 1'b1, '{KIND_T0,     4'd0, 4'd0, ERR_NONE,       1'b0, 1'b0}},
        '{8'h71, 1'b1, 1'b1, '{KIND_TA,     4'd1, 4'd0, ERR_FI,         1'b1, 1'b0}},
        '{8'h3B, 1'b0, 1'b1, '{KIND_TS,     4'd0, 4'd0, ERR_NONE,       1'b0, 1'b0}},
        '{8'h10, 1'b0, 1'b1, '{KIND_T0,     4'd0, 4'd0, ERR_NONE,       1'b0, 1'b0}},
        '{8'h10, 1'b1, 1'b1, '{KIND_TA,     4'd1, 4'd0, ERR_DI,         1'b1, 1'b0}},
        '{8'h3B, 1'b0, 1'b1, '{KIND_TS,     4'd0, 4'd0, ERR_NONE,       1'b0, 1'b0}},
        '{8'h02, 1'b0, 1'b1, '{KIND_T0,     4'd0, 4'd0, ERR_NONE,       1'b0, 1'b0}},
        '{8'h41, 1'b1, 1'b1, '{KIND_HIST,   4'd0, 4'd0, ERR_HIST_SHORT, 1'b1, 1'b0}},
        '{8'h3B, 1'b0, 1'b1, '{KIND_TS,     4'd0, 4'd0, ERR_NONE,       1'b0, 1'b0}},
        '{8'h80, 1'b0, 1'b1, '{KIND_T0,     4'd0, 4'd0, ERR_NONE,       1'b0, 1'b0}},
        '{8'h01, 1'b1, 1'b1, '{KIND_TD,     4'd1, 4'd1, ERR_TCK_ABSENT, 1'b1, 1'b0}},
        '{8'h3B, 1'b0, 1'b1, '{KIND_TS,     4'd0, 4'd0, ERR_NONE,       1'b0, 1'b0}},
        '{8'h80, 1'b0, 1'b1, '{KIND_T0,     4'd0, 4'd0, ERR_NONE,       1'b0, 1'b0}},
        '{8'h01, 1'b0, 1'b1, '{KIND_TD,     4'd1, 4'd1, ERR_NONE,       1'b0, 1'b0}},
        '{8'h00, 1'b1, 1'b1, '{KIND_TCK,    4'd0, 4'd1, ERR_TCK_BAD,    1'b1, 1'b0}},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'h60, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'h00, 1'b1, 1'b0, '0}
    };

    // Predictor state: a private copy of the parser.
    t_phase     pr_phase;
    logic [3:0] pr_pending;
    logic [3:0] pr_group;
    logic [3:0] pr_proto;
    logic [3:0] pr_hist_left;
    logic       pr_tck_due;
    logic [7:0] pr_xor;
    logic [3:0] pr_marks;
    t_err       pr_err;

    t_result    expected_results [$];
    logic [7:0] atr_data [$];
    bit         atr_final [$];

    int  send_idle_pct = 28;
    int  recv_idle_pct = 55;
    bit  hold_req = 1'b0;
    bit  hold_taken = 1'b0;
    int  hold_left = 0;
    int  cycle_count = 0;
    int  mismatch_count = 0;
    int  bytes_sent = 0;
    int  results_seen = 0;
    int  atrs_ended = 0;
    int  atrs_good = 0;
    int  input_stall_cycles = 0;
    logic [15:0] err_codes_hit = '0;
    t_result got_res;
    t_result want_res;

    function automatic void model_clear();
        pr_phase     = PH_TS;
        pr_pending   = '0;
        pr_group     = '0;
        pr_proto     = '0;
        pr_hist_left = '0;
        pr_tck_due   = 1'b0;
        pr_xor       = '0;
        pr_marks     = '0;
        pr_err       = ERR_NONE;
    endfunction

    // Keep only the first error of an ATR.
    function automatic void raise_err(input t_err code);
        if (pr_err == ERR_NONE)
            pr_err = code;
    endfunction

    function automatic t_phase phase_after_iface();
        if (pr_hist_left != 4'd0)
            return PH_HIST;
        else if (pr_tck_due)
            return PH_TCK;
        return PH_DONE;
    endfunction

    // Check a TA/TB/TC byte (slot 0, 1, 2) against its group's rules.
    function automatic void iface_check(input logic [1:0] slot, input logic [7:0] b);
        logic [3:0] bitm;
        bitm = 4'(1 << slot);
        if (pr_group == GROUP_FIRST) begin
            if (slot == 2'd0) begin
                if (FI_BAD_MASK[b[7:4]])
                    raise_err(ERR_FI);
                else if (DI_BAD_MASK[b[3:0]])
                    raise_err(ERR_DI);
            end
        end else if (pr_group == GROUP_SECOND) begin
            if (slot == 2'd0 && (b & TA2_RFU_MASK) != 8'h00)
                raise_err(ERR_TA2_RFU);
            if (slot == 2'd2 && b == 8'h00)
                raise_err(ERR_TC2);
        end else if (pr_proto == PROT_T1) begin
            // Only the first TA/TB/TC seen under T=1 counts.
            if ((pr_marks & bitm) == 4'd0) begin
                pr_marks = pr_marks | bitm;
                if (slot == 2'd0 && (b == 8'h00 || b == BYTE_ONES))
                    raise_err(ERR_IFSC);
                if (slot == 2'd1 && (b & BWI_MASK) > BWI_MAX)
                    raise_err(ERR_BWI);
                if (slot == 2'd2 && (b & TC_T1_MASK) != 8'h00)
                    raise_err(ERR_TC_T1);
            end
        end else if (pr_proto == PROT_T15 && slot == 2'd0) begin
            if (!pr_marks[MARK_T15_TA]) begin
                pr_marks[MARK_T15_TA] = 1'b1;
                if ((b & CLASS_RFU_MASK) != 8'h00 || (b & CLASS_MASK) == 8'h00)
                    raise_err(ERR_CLASS);
            end
        end
    endfunction

    // Advance the private parser by one byte and return the result it owes.
    function automatic t_result atr_predict(input logic [7:0] b, input logic is_final);
        t_result    r;
        logic [1:0] slot;
        r = '0;
        slot = 2'd0;
        if (pr_phase != PH_TS)
            pr_xor = pr_xor ^ b;
        case (pr_phase)
            PH_TS: begin
                r.kind = KIND_TS;
                pr_phase = PH_T0;
            end
            PH_T0: begin
                r.kind = KIND_T0;
                pr_pending = b[7:4];
                pr_hist_left = b[3:0];
                pr_group = GROUP_FIRST;
                pr_phase = (pr_pending != 4'd0) ? PH_IFACE : phase_after_iface();
            end
            PH_IFACE: begin
                // Take the lowest indicated byte; TD comes last in a group.
                while (slot < 2'd3 && !pr_pending[slot])
                    slot = slot + 2'd1;
                pr_pending[slot] = 1'b0;
                r.kind = t_kind'(KIND_TA + slot);
                r.group = pr_group;
                if (slot == 2'd3) begin
                    pr_proto = b[3:0];
                    if (pr_proto != 4'd0)
                        pr_tck_due = 1'b1;
                    pr_pending = b[7:4];
                    if (pr_group < GROUP_MAX)
                        pr_group = pr_group + 4'd1;
                end else begin
                    iface_check(slot, b);
                end
                if (pr_pending == 4'd0)
                    pr_phase = phase_after_iface();
            end
            PH_HIST: begin
                r.kind = KIND_HIST;
                pr_hist_left = pr_hist_left - 4'd1;
                if (pr_hist_left == 4'd0)
                    pr_phase = pr_tck_due ? PH_TCK : PH_DONE;
            end
            PH_TCK: begin
                r.kind = KIND_TCK;
                if (pr_xor != 8'h00)
                    raise_err(ERR_TCK_BAD);
                pr_phase = PH_DONE;
            end
            default: begin
                r.kind = KIND_EXCESS;
                raise_err(ERR_EXCESS);
                pr_phase = PH_DONE;
            end
        endcase
        if (is_final) begin
            if (pr_phase == PH_T0 || pr_phase == PH_IFACE)
                raise_err(ERR_TRUNC);
            else if (pr_phase == PH_HIST)
                raise_err(ERR_HIST_SHORT);
            else if (pr_phase == PH_TCK)
                raise_err(ERR_TCK_ABSENT);
        end
        r.proto = pr_proto;
        r.err = pr_err;
        r.done = is_final;
        r.ok = is_final && (pr_err == ERR_NONE);
        if (is_final)
            model_clear();
        return r;
    endfunction

    // Offer one byte, hold it until taken, then queue what it should produce.
    task automatic offer_byte(input logic [7:0] d, input logic is_final,
                              input logic typed, input t_result typed_res);
        t_result pred;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data_byte <= d;
        i_is_last <= is_final;
        do @(posedge i_clk); while (o_stall);
        pred = atr_predict(d, is_final);
        expected_results.push_back(typed ? typed_res : pred);
        bytes_sent++;
    endtask

    // Build one ATR into atr_data/atr_final. Most are well formed with random
    // content; some are cut short, some carry excess bytes, a few are noise.
    task automatic make_atr();
        logic [3:0] ind;
        logic [3:0] next_ind;
        logic [3:0] proto;
        logic [7:0] v;
        logic [7:0] ck;
        int         hist_n;
        int         td_n;
        int         grp;
        int         cut;
        bit         tck_due;
        atr_data.delete();
        atr_final.delete();
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 8)) atr_data.push_back(8'($urandom_range(0, 255)));
        end else begin
            atr_data.push_back(8'($urandom_range(0, 255)));
            hist_n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 4);
            // Mostly short chains; now and then a long one to saturate the group.
            td_n = ($urandom_range(0, 11) == 0) ? $urandom_range(12, 18) : $urandom_range(0, 3);
            ind = 4'($urandom_range(0, 15));
            ind[3] = (td_n > 0);
            atr_data.push_back({ind, 4'(hist_n)});
            tck_due = 1'b0;
            grp = 0;
            forever begin
                for (int s = 0; s < 3; s++) begin
                    if (ind[s]) begin
                        case ($urandom_range(0, 4))
                            0: v = 8'h00;
                            1: v = 8'hFF;
                            2: v = {4'($urandom_range(0, 9)), 4'($urandom_range(1, 15))};
                            3: v = 8'($urandom_range(1, 7)) | ($urandom_range(0, 1) ? 8'hC0 : 8'h00);
                            default: v = 8'($urandom_range(0, 255));
                        endcase
                        atr_data.push_back(v);
                    end
                end
                if (!ind[3])
                    break;
                grp++;
                case ($urandom_range(0, 3))
                    0: proto = 4'd0;
                    1: proto = PROT_T1;
                    2: proto = PROT_T15;
                    default: proto = 4'($urandom_range(0, 15));
                endcase
                next_ind = 4'($urandom_range(0, 15));
                next_ind[3] = (grp < td_n);
                atr_data.push_back({next_ind, proto});
                if (proto != 4'd0)
                    tck_due = 1'b1;
                ind = next_ind;
            end
            repeat (hist_n) atr_data.push_back(8'($urandom_range(0, 255)));
            if (tck_due) begin
                ck = 8'h00;
                for (int i = 1; i < atr_data.size(); i++)
                    ck = ck ^ atr_data[i];
                // Corrupt the check byte now and then.
                if ($urandom_range(0, 7) == 0)
                    ck = ck ^ 8'($urandom_range(1, 255));
                atr_data.push_back(ck);
            end
            case ($urandom_range(0, 9))
                0: begin
                    cut = $urandom_range(0, atr_data.size() - 1);
                    while (atr_data.size() > cut + 1)
                        void'(atr_data.pop_back());
                end
                1: repeat ($urandom_range(1, 3)) atr_data.push_back(8'($urandom_range(0, 255)));
                default: ;
            endcase
        end
        foreach (atr_data[i])
            atr_final.push_back(i == atr_data.size() - 1);
    endtask

    // Receiver: check each taken result and pick the next stall value. The
    // long hold-off is counted here, so the sender keeps offering meanwhile.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            got_res = '{t_kind'(o_byte_kind), o_group_number, o_protocol_t,
                        t_err'(o_error_code), o_done_res, o_atr_ok};
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("result with nothing queued: kind=%0d err=%0d done=%0d",
                             o_byte_kind, o_error_code, o_done_res);
            end else begin
                want_res = expected_results.pop_front();
                if (got_res !== want_res) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("mismatch at result %0d: kind %0d/%0d group %0d/%0d %s",
                                 results_seen, want_res.kind, o_byte_kind, want_res.group,
                                 o_group_number,
                                 $sformatf("proto %0d/%0d err %0d/%0d done %0d/%0d ok %0d/%0d",
                                           want_res.proto, o_protocol_t, want_res.err,
                                           o_error_code, want_res.done, o_done_res,
                                           want_res.ok, o_atr_ok));
                end
            end
            if (o_done_res === 1'b1) begin
                atrs_ended++;
                if (o_atr_ok === 1'b1)
                    atrs_good++;
                err_codes_hit[o_error_code] = 1'b1;
            end
        end
        if (i_valid && o_stall)
            input_stall_cycles++;
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (hold_req && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // Watchdog: drop the run if it stops making progress.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        int random_sent;
        model_clear();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table first, both sides idling.
        foreach (directed_rows[i])
            offer_byte(directed_rows[i].data, directed_rows[i].is_final,
                       directed_rows[i].typed, directed_rows[i].res);

        // Random ATRs, switching the idle mix by thirds. The last third runs
        // flat out and starts with a long receiver hold-off to fill the block.
        random_sent = 0;
        while (random_sent < RANDOM_BYTES) begin
            if (random_sent >= 2 * RANDOM_BYTES / 3 && !hold_req) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                hold_req = 1'b1;
            end else if (random_sent >= RANDOM_BYTES / 3 && send_idle_pct == 28) begin
                send_idle_pct = 55;
                recv_idle_pct = 28;
            end
            make_atr();
            foreach (atr_data[i])
                offer_byte(atr_data[i], atr_final[i], 1'b0, '0);
            random_sent += atr_data.size();
        end
        i_valid <= 1'b0;

        // Drain, then allow the pipeline latency to settle.
        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Run covered %0d bytes in %0d ATRs, %0d of them judged valid.",
                 bytes_sent, atrs_ended, atrs_good);
        $display("Final error codes seen: %0d distinct; input held off %0d cycles.",
                 $countones(err_codes_hit), input_stall_cycles);
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
